[rtl/athm_pkg.sv]
`timescale 1ns / 1ps

package athm_pkg;

    // Window and sample geometry
    localparam int WINDOW     = 20;
    localparam int TEMP_WIDTH = 12;
    localparam int BAND_WIDTH = 11;

    localparam int WIN_LOG = $clog2(WINDOW);
    localparam int POS_W   = WIN_LOG;
    localparam int SUM_W   = TEMP_WIDTH + WIN_LOG;

    // Limit minus band, and its value scaled by the window length
    localparam int DIFF_W = ((TEMP_WIDTH > BAND_WIDTH) ? TEMP_WIDTH : (BAND_WIDTH + 1)) + 1;
    localparam int THR_W  = DIFF_W + WIN_LOG;

    // Reciprocal of the window length for the mean (exact over the sum range)
    localparam int RECIP_SHIFT = TEMP_WIDTH + 2 * WIN_LOG + 1;
    localparam int RECIP_W     = RECIP_SHIFT - WIN_LOG + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + WINDOW - 1) / WINDOW);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = (TEMP_WIDTH > BAND_WIDTH) ? TEMP_WIDTH : BAND_WIDTH;

    localparam logic signed [TEMP_WIDTH-1:0] LIMIT_RESET = TEMP_WIDTH'(320);
    localparam logic [BAND_WIDTH-1:0]        BAND_RESET  = BAND_WIDTH'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_TEMP = 1'b0,
        CFG_BAND     = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_ON   = 2'd1,
        OP_OFF  = 2'd2,
        OP_STOP = 2'd3
    } opcode_t;

    typedef struct packed {
        logic                         sample_valid;
        logic signed [TEMP_WIDTH-1:0] temperature;
        opcode_t                      opcode;
    } req_t;

    typedef struct packed {
        logic                         heater_on;
        logic                         pump_on;
        logic                         holding;
        logic signed [TEMP_WIDTH-1:0] average_temperature;
    } rsp_t;

    // (limit - band) * WINDOW, full width, never wraps
    function automatic logic signed [THR_W-1:0] scale_diff(
        input logic signed [TEMP_WIDTH-1:0] limit,
        input logic [BAND_WIDTH-1:0]        band
    );
        logic signed [THR_W-1:0] diff;
        diff = THR_W'(limit) - THR_W'($signed({1'b0, band}));
        return diff * THR_W'(WINDOW);
    endfunction

endpackage

[rtl/athm_ring.sv]
`timescale 1ns / 1ps

module athm_ring (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   load,
    input  logic signed [athm_pkg::TEMP_WIDTH-1:0] temperature,
    output logic signed [athm_pkg::SUM_W-1:0]      window_sum
);

    localparam logic [athm_pkg::POS_W-1:0] POS_LAST = athm_pkg::POS_W'(athm_pkg::WINDOW - 1);

    logic signed [athm_pkg::TEMP_WIDTH-1:0] ring_reg [athm_pkg::WINDOW];
    logic [athm_pkg::POS_W-1:0]             pos_reg;
    logic [athm_pkg::POS_W-1:0]             pos_next;
    logic signed [athm_pkg::SUM_W-1:0]      sum_reg;
    logic signed [athm_pkg::SUM_W-1:0]      sum_next;
    logic signed [athm_pkg::TEMP_WIDTH-1:0] oldest;

    // Running sum: add the new sample, drop the one it replaces
    always_comb
    begin
        oldest   = ring_reg[pos_reg];
        sum_next = sum_reg + athm_pkg::SUM_W'(temperature) - athm_pkg::SUM_W'(oldest);
        pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < athm_pkg::WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (load)
        begin
            ring_reg[pos_reg] <= temperature;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
        end
    end

    assign window_sum = sum_reg;

endmodule

[rtl/athm_ctrl.sv]
`timescale 1ns / 1ps

module athm_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               move,
    input  athm_pkg::opcode_t                  opcode,
    input  logic signed [athm_pkg::SUM_W-1:0]  window_sum,
    input  logic signed [athm_pkg::THR_W-1:0]  thr_hi,
    input  logic signed [athm_pkg::THR_W-1:0]  thr_lo,
    output athm_pkg::rsp_t                     result
);

    logic heat_reg, heat_next;
    logic pump_reg, pump_next;
    logic hold_reg, hold_next;
    athm_pkg::rsp_t result_reg;
    athm_pkg::rsp_t result_next;

    logic signed [athm_pkg::THR_W-1:0]      sum_ext;
    logic                                   below_hi;
    logic                                   below_lo;
    logic                                   neg;
    logic [athm_pkg::SUM_W-1:0]             mag;
    logic [athm_pkg::PROD_W-1:0]            prod;
    logic [athm_pkg::TEMP_WIDTH-1:0]        quo;
    logic signed [athm_pkg::TEMP_WIDTH-1:0] mean;

    // Exact threshold tests against limit * WINDOW and (limit - band) * WINDOW
    always_comb
    begin
        sum_ext  = athm_pkg::THR_W'(window_sum);
        below_hi = sum_ext < thr_hi;
        below_lo = sum_ext < thr_lo;
    end

    // Mean, truncated toward zero: magnitude times reciprocal, sign restored
    always_comb
    begin
        neg  = window_sum[athm_pkg::SUM_W-1];
        mag  = neg ? athm_pkg::SUM_W'(-window_sum) : athm_pkg::SUM_W'(window_sum);
        prod = athm_pkg::PROD_W'(mag) * athm_pkg::PROD_W'(athm_pkg::RECIP);
        quo  = prod[athm_pkg::RECIP_SHIFT +: athm_pkg::TEMP_WIDTH];
        mean = neg ? $signed(-quo) : $signed(quo);
    end

    // Command handling and hysteresis
    always_comb
    begin
        heat_next = heat_reg;
        pump_next = pump_reg;
        hold_next = hold_reg;
        case (opcode)
            athm_pkg::OP_ON:
            begin
                pump_next = 1'b1;
                if (below_hi)
                begin
                    heat_next = 1'b1;
                end
                else
                begin
                    hold_next = 1'b1;
                end
            end
            athm_pkg::OP_OFF:
            begin
                heat_next = 1'b0;
                pump_next = 1'b0;
                hold_next = 1'b0;
            end
            athm_pkg::OP_STOP:
            begin
                heat_next = 1'b0;
            end
            default:
            begin
                if (heat_reg && !below_hi)
                begin
                    heat_next = 1'b0;
                    hold_next = 1'b1;
                end
                else if (hold_reg && below_lo)
                begin
                    heat_next = 1'b1;
                    hold_next = 1'b0;
                end
            end
        endcase

        result_next.heater_on           = heat_next;
        result_next.pump_on             = pump_next;
        result_next.holding             = hold_next;
        result_next.average_temperature = mean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_reg <= 1'b0;
            pump_reg <= 1'b0;
            hold_reg <= 1'b0;
        end
        else if (move)
        begin
            heat_reg <= heat_next;
            pump_reg <= pump_next;
            hold_reg <= hold_next;
        end
    end

    // Result register, payload only
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/averaged_hysteresis_thermostat.sv]
`timescale 1ns / 1ps

// Averaged hysteresis thermostat.
// req channel (req_valid / req_stall / req): one item per sample slot, with
//   an optional temperature sample and a command (none, on, off, stop).
// rsp channel (rsp_valid / rsp_stall / rsp): exactly one result per item:
//   heater, pump and hold state after the item, and the window mean.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): limit and band
//   registers; cfg_ready is always high. Write only while no item is in flight.
// Throughput: one item per cycle while no result is held by rsp_stall. The
//   running sum and the ring update happen at acceptance; the decision and
//   the mean (a reciprocal multiply) are computed from the input register
//   into the result register, which drives rsp_valid.
// When rsp_stall holds a result, one more item is taken into the input
//   register; after that req_stall goes high until the result is taken.
// Reset (rst_n low, asynchronous) empties the pipeline, clears the 20-entry
//   sample ring, the sum, heater, pump and hold, and loads limit 320 and
//   band 32 (1/16 degree units). No clearing pass is needed after reset.

module averaged_hysteresis_thermostat (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  athm_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output athm_pkg::rsp_t                      rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [athm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [athm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                                   rsp_free;
    logic                                   accept;
    logic                                   move;
    logic                                   s1_valid_reg, s1_valid_next;
    logic                                   rsp_valid_reg, rsp_valid_next;
    athm_pkg::opcode_t                      s1_op_reg;
    logic signed [athm_pkg::SUM_W-1:0]      window_sum;

    logic signed [athm_pkg::TEMP_WIDTH-1:0] limit_reg, limit_next;
    logic [athm_pkg::BAND_WIDTH-1:0]        band_reg, band_next;
    logic signed [athm_pkg::THR_W-1:0]      thr_hi_reg, thr_hi_next;
    logic signed [athm_pkg::THR_W-1:0]      thr_lo_reg, thr_lo_next;
    logic                                   cfg_write;

    // Handshake: the input register advances whenever the result register frees
    always_comb
    begin
        rsp_free  = !rsp_valid_reg || !rsp_stall;
        req_stall = s1_valid_reg && !rsp_free;
        accept    = req_valid && !req_stall;
        move      = s1_valid_reg && rsp_free;

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Command of the item waiting in the input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= req.opcode;
        end
    end

    // Configuration: keep raw values and thresholds pre-scaled by WINDOW
    always_comb
    begin
        cfg_write   = cfg_valid && cfg_ready;
        limit_next  = limit_reg;
        band_next   = band_reg;
        thr_hi_next = thr_hi_reg;
        thr_lo_next = thr_lo_reg;
        case (athm_pkg::cfg_index_t'(cfg_index))
            athm_pkg::CFG_MAX_TEMP:
            begin
                limit_next  = cfg_data[athm_pkg::TEMP_WIDTH-1:0];
                thr_hi_next = athm_pkg::scale_diff(limit_next, '0);
                thr_lo_next = athm_pkg::scale_diff(limit_next, band_reg);
            end
            athm_pkg::CFG_BAND:
            begin
                band_next   = cfg_data[athm_pkg::BAND_WIDTH-1:0];
                thr_lo_next = athm_pkg::scale_diff(limit_reg, band_next);
            end
            default:
            begin
                limit_next = limit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= athm_pkg::LIMIT_RESET;
            band_reg   <= athm_pkg::BAND_RESET;
            thr_hi_reg <= athm_pkg::scale_diff(athm_pkg::LIMIT_RESET, '0);
            thr_lo_reg <= athm_pkg::scale_diff(athm_pkg::LIMIT_RESET, athm_pkg::BAND_RESET);
        end
        else if (cfg_write)
        begin
            limit_reg  <= limit_next;
            band_reg   <= band_next;
            thr_hi_reg <= thr_hi_next;
            thr_lo_reg <= thr_lo_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Sample ring and running sum, updated at acceptance of a flagged sample
    athm_ring u_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && req.sample_valid),
        .temperature (req.temperature),
        .window_sum  (window_sum)
    );

    // Decision, mean and result register
    athm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .move       (move),
        .opcode     (s1_op_reg),
        .window_sum (window_sum),
        .thr_hi     (thr_hi_reg),
        .thr_lo     (thr_lo_reg),
        .result     (rsp)
    );

    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/athm_checker.sv]
`timescale 1ns / 1ps

module athm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input athm_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input athm_pkg::rsp_t rsp
);

    // A held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Input is only stalled when a result is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled without a waiting result");

    // Every accepted item is followed by a shown result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##2 rsp_valid)
        else $error("no result after accepted item");

    // Device off leaves everything off
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.opcode == athm_pkg::OP_OFF)
        ##1 (!rsp_valid || !rsp_stall)
        |=> rsp_valid && !rsp.heater_on && !rsp.pump_on && !rsp.holding)
        else $error("device off did not clear outputs");

    // Heater and hold only exist while the pump runs
    a_pump: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.pump_on |-> !rsp.heater_on && !rsp.holding)
        else $error("heater or hold active with pump off");

endmodule

bind averaged_hysteresis_thermostat athm_checker u_athm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

[sim/averaged_hysteresis_thermostat_test.sv]
`timescale 1ns / 1ps

module averaged_hysteresis_thermostat_test;

    import athm_pkg::*;

    // Tracks window, heater, pump and hold state; predicts each status item
    class thermostat_tracker;
        int   ring [WINDOW];
        int   wr_pos;
        int   window_sum;
        bit   heating;
        bit   pumping;
        bit   hold;
        int   limit;
        int   band;
        int   items_taken;
        int   mismatches;
        rsp_t expected_status [$];

        function new();
            foreach (ring[i])
                ring[i] = 0;
            wr_pos      = 0;
            window_sum  = 0;
            heating     = 1'b0;
            pumping     = 1'b0;
            hold        = 1'b0;
            limit       = 320;
            band        = 32;
            items_taken = 0;
            mismatches  = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_MAX_TEMP)
                limit = $signed(value[TEMP_WIDTH-1:0]);
            else
                band = value[BAND_WIDTH-1:0];
        endfunction

        // Accepted input item: update the window, then the control state
        function void note_item(req_t item);
            int   t;
            int   mean;
            rsp_t status;
            if (item.sample_valid)
            begin
                t = $signed(item.temperature);
                window_sum += t - ring[wr_pos];
                ring[wr_pos] = t;
                wr_pos = (wr_pos + 1) % WINDOW;
            end
            case (item.opcode)
                OP_ON:
                begin
                    pumping = 1'b1;
                    if (window_sum < limit * WINDOW)
                        heating = 1'b1;
                    else
                        hold = 1'b1;
                end
                OP_OFF:
                begin
                    heating = 1'b0;
                    pumping = 1'b0;
                    hold    = 1'b0;
                end
                OP_STOP:
                    heating = 1'b0;
                default:
                begin
                    // hysteresis: stop at the limit, restart below limit - band
                    if (heating && !(window_sum < limit * WINDOW))
                    begin
                        heating = 1'b0;
                        hold    = 1'b1;
                    end
                    else if (hold && window_sum < (limit - band) * WINDOW)
                    begin
                        heating = 1'b1;
                        hold    = 1'b0;
                    end
                end
            endcase
            mean = window_sum / WINDOW;
            status.heater_on           = heating;
            status.pump_on             = pumping;
            status.holding             = hold;
            status.average_temperature = mean[TEMP_WIDTH-1:0];
            expected_status.push_back(status);
            items_taken++;
        endfunction

        // Accepted status item: compare with the oldest prediction
        function void check_status(rsp_t got);
            rsp_t want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected status item %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            if (got.heater_on !== want.heater_on)
            begin
                $display("%0t: heater_on expected %b actual %b",
                         $time, want.heater_on, got.heater_on);
                mismatches++;
            end
            if (got.pump_on !== want.pump_on)
            begin
                $display("%0t: pump_on expected %b actual %b",
                         $time, want.pump_on, got.pump_on);
                mismatches++;
            end
            if (got.holding !== want.holding)
            begin
                $display("%0t: holding expected %b actual %b",
                         $time, want.holding, got.holding);
                mismatches++;
            end
            if (got.average_temperature !== want.average_temperature)
            begin
                $display("%0t: average_temperature expected %0d actual %0d", $time,
                         want.average_temperature, got.average_temperature);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    thermostat_tracker tracker = new;

    bit no_idle = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    averaged_hysteresis_thermostat DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Status side: take items, random stall, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                tracker.check_status(rsp);
            if (!hold_done && tracker.items_taken >= 700)
            begin
                hold_done = 1'b1;
                hold_left = 64;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (no_idle)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < 19);
        end
    end

    // Offer one item, with an optional idle gap, until it is taken
    task send_item(req_t item);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 19)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        tracker.note_item(item);
    endtask

    task write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait for every predicted status item
    task drain();
        int waited;
        req_valid <= 1'b0;
        waited = 0;
        while (tracker.pending() > 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    function req_t make_item(bit sv, int temp, opcode_t op);
        req_t item;
        item.sample_valid = sv;
        item.temperature  = temp[TEMP_WIDTH-1:0];
        item.opcode       = op;
        return item;
    endfunction

    // Mostly samples around the limit and band so hysteresis keeps toggling
    function req_t random_item(int lim, int bnd);
        int      pick;
        int      span;
        int      t;
        int      r;
        opcode_t op;
        pick = $urandom_range(0, 99);
        span = bnd + 48;
        if (pick < 60)
            t = lim - span + int'($urandom_range(0, 2 * span));
        else if (pick < 85)
            t = int'($urandom_range(0, 4095)) - 2048;
        else
            t = $urandom_range(0, 1) ? 2047 : -2048;
        if (t > 2047)
            t = 2047;
        if (t < -2048)
            t = -2048;
        r = $urandom_range(0, 99);
        if (r < 70)
            op = OP_NONE;
        else if (r < 82)
            op = OP_ON;
        else if (r < 91)
            op = OP_STOP;
        else
            op = OP_OFF;
        return make_item($urandom_range(0, 99) < 85, t, op);
    endfunction

    // Run limit
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int limits [8];
        int bands [8];
        int lim;
        int bnd;
        logic [CFG_DATA_W-1:0] band_data;

        limits = '{320, -2048, 2047, 0, -2048, 2047, 0, 0};
        bands  = '{32, 0, 2047, 2047, 2047, 0, 0, 0};
        limits[6] = int'($urandom_range(0, 4095)) - 2048;
        bands[6]  = $urandom_range(0, 2047);
        limits[7] = int'($urandom_range(200, 500));
        bands[7]  = $urandom_range(0, 80);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset limit 320, band 32
        send_item(make_item(1'b0, 0, OP_NONE));
        send_item(make_item(1'b0, -1, OP_ON));
        repeat (4) send_item(make_item(1'b1, 2047, OP_NONE));
        // on while at or above the limit: hold, heater untouched
        send_item(make_item(1'b1, 2047, OP_ON));
        repeat (3) send_item(make_item(1'b1, -2048, OP_NONE));
        send_item(make_item(1'b1, -2048, OP_STOP));
        // sample ignored when not flagged
        send_item(make_item(1'b0, 'h555, OP_NONE));
        send_item(make_item(1'b0, 'haaa, OP_NONE));
        send_item(make_item(1'b1, -2048, OP_ON));
        send_item(make_item(1'b1, 0, OP_OFF));
        send_item(make_item(1'b1, 1, OP_NONE));
        repeat (4) send_item(make_item(1'b1, 2047, OP_ON));
        send_item(make_item(1'b1, 2047, OP_NONE));
        send_item(make_item(1'b1, -2048, OP_STOP));
        repeat (3) send_item(make_item(1'b1, -2048, OP_NONE));
        drain();

        // Random phases, one limit and band setting each
        for (int ph = 0; ph < 8; ph++)
        begin
            lim = limits[ph];
            bnd = bands[ph];
            band_data = bnd[CFG_DATA_W-1:0];
            band_data[CFG_DATA_W-1] = $urandom_range(0, 1);
            write_register(CFG_MAX_TEMP, lim[CFG_DATA_W-1:0]);
            write_register(CFG_BAND, band_data);
            no_idle = (ph == 3);
            repeat (228) send_item(random_item(lim, bnd));
            no_idle = 1'b0;
            drain();
        end

        if (tracker.pending() > 0)
            $display("%0t: %0d status items never arrived", $time, tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
